@@ rtl/kptbl_pkg.sv @@
// kptbl_pkg: request, result and internal operation types for the keyed preset table
// shared by the front, queue, back and top level; depends on nothing
`default_nettype none

package kptbl_pkg;

	typedef enum logic [1:0] {
		CMD_BLOB  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_GET   = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_code_t;

	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_GET    = 1'b1;

	localparam logic [7:0] BLOB_VERSION = 8'h01;
	localparam logic [7:0] BLOB_END_KEY = 8'hFF;

	// value bytes that count per record, capped by the 32-bit value word
	localparam int VALUE_BYTES     = 4;
	localparam int MAX_VALUE_BYTES = 4;
	localparam int EFF_VALUE_BYTES =
		(VALUE_BYTES < MAX_VALUE_BYTES) ? VALUE_BYTES : MAX_VALUE_BYTES;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		cmd_code_t          command;
		logic [7:0]         key;
		logic [7:0]         blob_byte;
		logic               blob_last;
		logic signed [31:0] set_value;
		logic [7:0]         set_length;
	} cmd_t;

	typedef struct packed {
		logic               result_kind;
		logic               load_ok;
		logic signed [31:0] entry_value;
		logic               entry_present;
		logic [7:0]         entry_length;
	} rsp_t;

	// one classified operation for the back part; write or clear runs before read or status
	typedef struct packed {
		logic        do_clear;
		logic        do_write;
		logic        do_read;
		logic        do_status;
		logic        status_ok;
		logic [7:0]  key;
		logic [31:0] value;
		logic [7:0]  length;
	} op_t;

endpackage

`default_nettype wire

@@ rtl/kptbl_front.sv @@
// kptbl_front: accepts requests, runs the blob parser and emits table operations
// depends on kptbl_pkg
`default_nettype none

module kptbl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  kptbl_pkg::cmd_t  cmd,
	input  logic             q_full,
	output logic             q_push,
	output kptbl_pkg::op_t   q_op
);
	import kptbl_pkg::*;

	typedef enum logic [2:0] {
		PH_VERSION = 3'd0,
		PH_SECOND  = 3'd1,
		PH_KEY     = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_VALUE   = 3'd4,
		PH_DRAIN   = 3'd5
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  rec_key_q, rec_key_n;
	logic [7:0]  rec_len_q, rec_len_n;
	logic [7:0]  taken_q, taken_n;
	logic [31:0] acc_q, acc_n;
	logic        failed_q, failed_n;
	logic        accept;
	logic        blob_upd;
	op_t         op;

	always_comb begin
		accept   = cmd_valid && !q_full;
		phase_n  = phase_q;
		rec_key_n = rec_key_q;
		rec_len_n = rec_len_q;
		taken_n  = taken_q;
		acc_n    = acc_q;
		failed_n = failed_q;
		op       = '0;
		blob_upd = 1'b0;
		unique case (cmd.command)
			CMD_BLOB: begin
				blob_upd = 1'b1;
				unique case (phase_q)
					PH_VERSION: begin
						failed_n = (cmd.blob_byte != BLOB_VERSION) || cmd.blob_last;
						phase_n  = PH_SECOND;
					end
					PH_SECOND, PH_KEY: begin
						// table is wiped at the second byte, whatever the version said
						if (phase_q == PH_SECOND) begin
							op.do_clear = 1'b1;
						end
						if (phase_q == PH_SECOND && failed_q) begin
							phase_n = PH_DRAIN;
						end else if (cmd.blob_byte == BLOB_END_KEY) begin
							phase_n = PH_DRAIN;
						end else begin
							rec_key_n = cmd.blob_byte;
							phase_n   = PH_LENGTH;
							if (cmd.blob_last) begin
								failed_n = 1'b1;
							end
						end
					end
					PH_LENGTH: begin
						rec_len_n = cmd.blob_byte;
						taken_n   = 8'd0;
						acc_n     = 32'd0;
						if (cmd.blob_byte == 8'd0) begin
							// empty record stored at once
							op.do_write = 1'b1;
							op.key      = rec_key_q;
							phase_n     = PH_KEY;
						end else begin
							phase_n = PH_VALUE;
							if (cmd.blob_last) begin
								failed_n = 1'b1;
							end
						end
					end
					PH_VALUE: begin
						taken_n = taken_q + 8'd1;
						if (taken_q < 8'(EFF_VALUE_BYTES)) begin
							acc_n = acc_q | (32'(cmd.blob_byte) << {taken_q[1:0], 3'b000});
						end
						if (taken_n == rec_len_q) begin
							op.do_write = 1'b1;
							op.key      = rec_key_q;
							op.value    = acc_n;
							op.length   = rec_len_q;
							phase_n     = PH_KEY;
						end else if (cmd.blob_last) begin
							failed_n = 1'b1;
						end
					end
					default: begin
						// drain and unused codes ignore bytes up to the last one
					end
				endcase
				if (cmd.blob_last) begin
					op.do_status = 1'b1;
					op.status_ok = !failed_n;
					phase_n   = PH_VERSION;
					rec_key_n = 8'd0;
					rec_len_n = 8'd0;
					taken_n   = 8'd0;
					acc_n     = 32'd0;
					failed_n  = 1'b0;
				end
			end
			CMD_SET: begin
				op.do_write = 1'b1;
				op.key      = cmd.key;
				op.value    = cmd.set_value;
				op.length   = cmd.set_length;
			end
			CMD_GET: begin
				op.do_read = 1'b1;
				op.key     = cmd.key;
			end
			CMD_CLEAR: begin
				op.do_clear = 1'b1;
			end
		endcase
	end

	assign cmd_stall = q_full;
	assign q_push    = accept && (op.do_clear || op.do_write || op.do_read || op.do_status);
	assign q_op      = op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_VERSION;
			rec_key_q <= 8'd0;
			rec_len_q <= 8'd0;
			taken_q   <= 8'd0;
			acc_q     <= 32'd0;
			failed_q  <= 1'b0;
		end else if (accept && blob_upd) begin
			phase_q   <= phase_n;
			rec_key_q <= rec_key_n;
			rec_len_q <= rec_len_n;
			taken_q   <= taken_n;
			acc_q     <= acc_n;
			failed_q  <= failed_n;
		end
	end

endmodule

`default_nettype wire

@@ rtl/kptbl_queue.sv @@
// kptbl_queue: short operation queue between the front and the back part
// depends on kptbl_pkg
`default_nettype none

module kptbl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kptbl_pkg::op_t  push_op,
	output logic            full,
	input  logic            pop,
	output kptbl_pkg::op_t  pop_op,
	output logic            empty
);
	import kptbl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

	op_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_op   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

@@ rtl/kptbl_back.sv @@
// kptbl_back: table memory with per-entry valid bits, carries out queued operations
// and holds the result register; depends on kptbl_pkg
`default_nettype none

module kptbl_back #(
	parameter int KEY_COUNT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	output logic            q_pop,
	input  kptbl_pkg::op_t  q_op,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output kptbl_pkg::rsp_t rsp
);
	import kptbl_pkg::*;

	localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam logic [8:0] KEY_LIMIT = 9'(KEY_COUNT);

	logic [39:0]          mem [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;
	logic [IDX_W-1:0]     idx;
	logic                 in_range;
	logic                 advance;

	logic                 res_v_s1;
	logic                 res_get_s1;
	logic                 res_ok_s1;
	logic                 res_hit_s1;
	logic [39:0]          rd_data_s1;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic [7:0]           get_len;

	assign idx      = q_op.key[IDX_W-1:0];
	assign in_range = ({1'b0, q_op.key} < KEY_LIMIT);
	assign advance  = res_v_s1 && (!rsp_valid_q || !rsp_stall);
	assign q_pop    = !q_empty && (!res_v_s1 || advance);
	assign get_len  = res_hit_s1 ? rd_data_s1[7:0] : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			res_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_op.do_clear) begin
				vld_q <= '0;
			end else if (q_pop && q_op.do_write && in_range) begin
				vld_q[idx] <= 1'b1;
			end
			if (q_pop) begin
				res_v_s1 <= q_op.do_read || q_op.do_status;
			end else if (advance) begin
				res_v_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_op.do_write && in_range) begin
			mem[idx] <= {q_op.value, q_op.length};
		end
		if (q_pop && q_op.do_read) begin
			rd_data_s1 <= mem[idx];
		end
		if (q_pop) begin
			res_get_s1 <= q_op.do_read;
			res_ok_s1  <= q_op.status_ok;
			res_hit_s1 <= in_range && vld_q[idx];
		end
		if (advance) begin
			if (res_get_s1) begin
				rsp_q.result_kind   <= RES_GET;
				rsp_q.load_ok       <= 1'b0;
				rsp_q.entry_value   <= res_hit_s1 ? rd_data_s1[39:8] : 32'd0;
				rsp_q.entry_present <= (get_len != 8'd0);
				rsp_q.entry_length  <= get_len;
			end else begin
				rsp_q.result_kind   <= RES_STATUS;
				rsp_q.load_ok       <= res_ok_s1;
				rsp_q.entry_value   <= 32'd0;
				rsp_q.entry_present <= 1'b0;
				rsp_q.entry_length  <= 8'd0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/keyed_preset_table_with_blob_loader_unit.sv @@
// keyed_preset_table_with_blob_loader_unit: top level of the keyed preset table
// depends on kptbl_pkg, kptbl_front, kptbl_queue and kptbl_back
`default_nettype none

// channel  | valid / stall        | payload  | carries
// ---------+----------------------+----------+-------------------------------------
// request  | cmd_valid / cmd_stall | cmd      | blob byte, set, get or clear request
// result   | rsp_valid / rsp_stall | rsp      | blob load status or get answer
//
// one request is taken per cycle while the queue is not full; a get answer or a load
// status passes from the queue through the table read stage into the result register
// the four-entry operation queue sets how long the request side runs on under a stalled
// result; when it fills, cmd_stall rises until the back part drains an entry
// asynchronous reset empties the table at once through per-entry valid bits, with no
// clearing pass; the clear request and a blob's second byte drop those bits all at once

module keyed_preset_table_with_blob_loader_unit #(
	parameter int KEY_COUNT = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  kptbl_pkg::cmd_t cmd,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output kptbl_pkg::rsp_t rsp
);
	import kptbl_pkg::*;

	// classified operations between the front and the back part
	logic q_push, q_full, q_pop, q_empty;
	op_t  push_op, pop_op;

	// front: takes each request while the queue is not full, tracks the blob parse, emits at most one operation
	kptbl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_op      (push_op)
	);

	// queue: lets the parser run ahead while a result waits to be taken
	kptbl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	// back: table writes, clears and reads, then the result register
	kptbl_back #(
		.KEY_COUNT (KEY_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_op      (pop_op),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
